// ===== rtl/core/fpex_pkg.sv =====
// Shared types, codes and constants of the float processing element.
package fpex_pkg;

	localparam int REG_COUNT_DEF     = 16;
	localparam int LANE_DEPTH_DEF    = 1024;
	localparam int PROGRAM_SLOTS_DEF = 256;
	localparam int QUEUE_DEPTH       = 4;
	localparam int LANE_COUNT        = 3;
	localparam int CFG_W             = 10;
	localparam logic [CFG_W-1:0] MAX_INSTR_RESET = 10'd1000;

	localparam logic [1:0] CMD_EXEC    = 2'd0;
	localparam logic [1:0] CMD_WRITE   = 2'd1;
	localparam logic [1:0] CMD_READ    = 2'd2;
	localparam logic [1:0] CMD_RESTART = 2'd3;

	localparam logic [7:0] OP_NOP   = 8'd0;
	localparam logic [7:0] OP_SETC  = 8'd1;
	localparam logic [7:0] OP_LOAD  = 8'd2;
	localparam logic [7:0] OP_ST    = 8'd3;
	localparam logic [7:0] OP_ADD   = 8'd4;
	localparam logic [7:0] OP_MUL   = 8'd5;
	localparam logic [7:0] OP_MAX   = 8'd6;
	localparam logic [7:0] OP_HALT  = 8'd7;

	localparam logic [2:0] ST_DONE    = 3'd0;
	localparam logic [2:0] ST_HALT    = 3'd1;
	localparam logic [2:0] ST_BAD     = 3'd2;
	localparam logic [2:0] ST_UNKNOWN = 3'd3;
	localparam logic [2:0] ST_LIMIT   = 3'd4;
	localparam logic [2:0] ST_LENGTH  = 3'd5;
	localparam logic [2:0] ST_STOPPED = 3'd6;

	localparam logic [3:0] K_NONE  = 4'd0;
	localparam logic [3:0] K_SETC  = 4'd1;
	localparam logic [3:0] K_LOAD  = 4'd2;
	localparam logic [3:0] K_STORE = 4'd3;
	localparam logic [3:0] K_ADD   = 4'd4;
	localparam logic [3:0] K_MUL   = 4'd5;
	localparam logic [3:0] K_MAX   = 4'd6;
	localparam logic [3:0] K_HWR   = 4'd7;
	localparam logic [3:0] K_HRD   = 4'd8;

	typedef struct packed {
		logic [3:0]  kind;
		logic [2:0]  status;
		logic [7:0]  dst;
		logic [7:0]  src1;
		logic [7:0]  src2;
		logic [1:0]  lane;
		logic [31:0] offset;
		logic [31:0] data;
	} item_t;

endpackage

// ===== rtl/core/fpex_if.sv =====
// Handshake channels for instruction beats and result beats.
interface fpex_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [7:0]  opcode;
	logic [7:0]  dest_index;
	logic [7:0]  first_source;
	logic [7:0]  second_source;
	logic [31:0] immediate;
	logic [1:0]  host_lane;
	logic [9:0]  host_offset;
	logic [31:0] host_data;

	modport source(output valid, cmd, opcode, dest_index, first_source, second_source,
		immediate, host_lane, host_offset, host_data, input ready);
	modport sink(input valid, cmd, opcode, dest_index, first_source, second_source,
		immediate, host_lane, host_offset, host_data, output ready);
endinterface

interface fpex_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [31:0] read_data;

	modport source(output valid, status, read_data, input ready);
	modport sink(input valid, status, read_data, output ready);
endinterface

// ===== rtl/core/fpex_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module fpex_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ===== rtl/core/fpex_queue.sv =====
// Short queue of classified items between the front and the back.
module fpex_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  fpex_pkg::item_t din,
	output logic            full,
	input  logic            pop,
	output fpex_pkg::item_t dout,
	output logic            empty
);
	import fpex_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);

	item_t         ent_q [QUEUE_DEPTH];
	logic [PW-1:0] wp_q;
	logic [PW-1:0] rp_q;
	logic [PW:0]   cnt_q;
	logic          do_push;
	logic          do_pop;

	assign full    = cnt_q == (PW+1)'(QUEUE_DEPTH);
	assign empty   = cnt_q == '0;
	assign dout    = ent_q[rp_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wp_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wp_q <= wp_q + 1'b1;
			end
			if (do_pop) begin
				rp_q <= rp_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end
endmodule

// ===== rtl/core/fpex_front.sv =====
// Front end: accepts beats, checks operands and keeps the run state and count.
module fpex_front #(
	parameter int REG_COUNT     = fpex_pkg::REG_COUNT_DEF,
	parameter int LANE_DEPTH    = fpex_pkg::LANE_DEPTH_DEF,
	parameter int PROGRAM_SLOTS = fpex_pkg::PROGRAM_SLOTS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [fpex_pkg::CFG_W-1:0] cfg_wdata,
	fpex_in_if.sink                    item,
	output logic                       push,
	output fpex_pkg::item_t            ent,
	input  logic                       full
);
	import fpex_pkg::*;

	logic             stopped_q;
	logic [CFG_W-1:0] count_q;
	logic [CFG_W-1:0] max_q;
	logic             d_ok;
	logic             s1_ok;
	logic             s2_ok;
	logic             lane_ok;
	logic             off_ok;
	logic             hlane_ok;
	logic             hoff_ok;
	logic             stop_set;
	logic             cnt_inc;
	logic             restart;

	assign item.ready = !full;
	assign push       = item.valid && !full;

	assign d_ok     = {1'b0, item.dest_index} < 9'(REG_COUNT);
	assign s1_ok    = {1'b0, item.first_source} < 9'(REG_COUNT);
	assign s2_ok    = {1'b0, item.second_source} < 9'(REG_COUNT);
	assign lane_ok  = item.first_source < 8'(LANE_COUNT);
	assign off_ok   = {1'b0, item.immediate} < 33'(LANE_DEPTH);
	assign hlane_ok = item.host_lane < 2'(LANE_COUNT);
	assign hoff_ok  = {7'b0, item.host_offset} < 17'(LANE_DEPTH);

	always_comb begin
		ent        = '0;
		ent.kind   = K_NONE;
		ent.status = ST_DONE;
		ent.dst    = item.dest_index;
		ent.src1   = item.first_source;
		ent.src2   = item.second_source;
		ent.lane   = item.first_source[1:0];
		ent.offset = item.immediate;
		ent.data   = item.immediate;
		stop_set   = 1'b0;
		cnt_inc    = 1'b0;
		restart    = 1'b0;
		case (item.cmd)
			CMD_EXEC: begin
				if (stopped_q) begin
					ent.status = ST_STOPPED;
				end else if (count_q >= max_q) begin
					ent.status = ST_LIMIT;
				end else if ({1'b0, count_q} >= 11'(PROGRAM_SLOTS)) begin
					ent.status = ST_LENGTH;
				end else begin
					cnt_inc = 1'b1;
					case (item.opcode)
						OP_NOP: ent.kind = K_NONE;
						OP_SETC: begin
							if (d_ok) ent.kind = K_SETC;
							else ent.status = ST_BAD;
						end
						OP_LOAD: begin
							if (d_ok && lane_ok && off_ok) ent.kind = K_LOAD;
							else ent.status = ST_BAD;
						end
						OP_ST: begin
							if (s2_ok && lane_ok && off_ok) ent.kind = K_STORE;
							else ent.status = ST_BAD;
						end
						OP_ADD, OP_MUL, OP_MAX: begin
							if (d_ok && s1_ok && s2_ok) begin
								ent.kind = (item.opcode == OP_ADD) ? K_ADD :
									(item.opcode == OP_MUL) ? K_MUL : K_MAX;
							end else begin
								ent.status = ST_BAD;
							end
						end
						OP_HALT: ent.status = ST_HALT;
						default: ent.status = ST_UNKNOWN;
					endcase
				end
				stop_set = ent.status != ST_DONE;
			end
			CMD_WRITE, CMD_READ: begin
				ent.lane   = item.host_lane;
				ent.offset = 32'(item.host_offset);
				ent.data   = item.host_data;
				if (hlane_ok && hoff_ok) begin
					ent.kind = (item.cmd == CMD_WRITE) ? K_HWR : K_HRD;
				end else begin
					ent.status = ST_BAD;
				end
			end
			CMD_RESTART: restart = 1'b1;
			default: ent.kind = K_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stopped_q <= 1'b0;
			count_q   <= '0;
			max_q     <= MAX_INSTR_RESET;
		end else begin
			if (cfg_we) begin
				max_q <= cfg_wdata;
			end
			if (push) begin
				if (restart) begin
					stopped_q <= 1'b0;
					count_q   <= '0;
				end else begin
					if (cnt_inc) begin
						count_q <= count_q + 1'b1;
					end
					if (stop_set) begin
						stopped_q <= 1'b1;
					end
				end
			end
		end
	end
endmodule

// ===== rtl/core/fpex_fpu.sv =====
// Five-stage single precision adder and multiplier with round to nearest even.
module fpex_fpu (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        is_mul,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic        done,
	output logic [31:0] res
);
	function automatic logic [5:0] lzc48(input logic [47:0] v);
		logic [5:0] n;
		n = 6'd48;
		for (int i = 0; i < 48; i++) begin
			if (v[i]) n = 6'(47 - i);
		end
		return n;
	endfunction

	logic        nan_a, nan_b, inf_a, inf_b, zero_a, zero_b, swap;
	logic        spec0;
	logic [31:0] sres0;
	logic [31:0] big, sml;

	logic v_s1, v_s2, v_s3, v_s4;

	logic        mul_s1, spec_s1, sl_s1, sub_s1, zs_s1;
	logic [31:0] sres_s1;
	logic [7:0]  el_s1, es_s1;
	logic [23:0] ml_s1, ms_s1;

	logic        spec_s2, sg_s2, zs_s2, st_s2;
	logic [31:0] sres_s2;
	logic [47:0] m_s2;
	logic signed [12:0] e_s2;

	logic        spec_s3, sg_s3, zs_s3, st_s3, zero_s3;
	logic [31:0] sres_s3;
	logic [47:0] m_s3;
	logic signed [12:0] e_s3;
	logic [5:0]  lz_s3;

	logic        spec_s4, sg_s4, zs_s4, st_s4, zero_s4;
	logic [31:0] sres_s4;
	logic [47:0] m_s4;
	logic signed [12:0] x_s4;

	logic [7:0]  dexp;
	logic [5:0]  dcap;
	logic [95:0] alw;
	logic [47:0] lg, sum, prod;
	logic signed [12:0] ecalc, lzs, sh;
	logic [12:0] rneg;
	logic [5:0]  rc;
	logic [95:0] rw;
	logic [47:0] mn;
	logic        stn, inc;
	logic [30:0] mag;
	logic [31:0] fin;

	assign nan_a  = (a[30:23] == 8'hFF) && (a[22:0] != '0);
	assign nan_b  = (b[30:23] == 8'hFF) && (b[22:0] != '0);
	assign inf_a  = (a[30:23] == 8'hFF) && (a[22:0] == '0);
	assign inf_b  = (b[30:23] == 8'hFF) && (b[22:0] == '0);
	assign zero_a = a[30:0] == '0;
	assign zero_b = b[30:0] == '0;
	assign swap   = a[30:0] < b[30:0];
	assign big    = swap ? b : a;
	assign sml    = swap ? a : b;

	always_comb begin
		spec0 = 1'b1;
		sres0 = '0;
		if (nan_a) begin
			sres0 = a | 32'h0040_0000;
		end else if (nan_b) begin
			sres0 = b | 32'h0040_0000;
		end else if (is_mul) begin
			if ((inf_a && zero_b) || (zero_a && inf_b)) sres0 = 32'hFFC0_0000;
			else if (inf_a || inf_b) sres0 = {a[31] ^ b[31], 8'hFF, 23'b0};
			else if (zero_a || zero_b) sres0 = {a[31] ^ b[31], 31'b0};
			else spec0 = 1'b0;
		end else begin
			if (inf_a && inf_b && (a[31] != b[31])) sres0 = 32'hFFC0_0000;
			else if (inf_a) sres0 = a;
			else if (inf_b) sres0 = b;
			else if (zero_a && zero_b) sres0 = {a[31] & b[31], 31'b0};
			else spec0 = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mul_s1  <= is_mul;
			spec_s1 <= spec0;
			sres_s1 <= sres0;
			sl_s1   <= big[31];
			sub_s1  <= a[31] ^ b[31];
			zs_s1   <= a[31] & b[31];
			el_s1   <= (big[30:23] == '0) ? 8'd1 : big[30:23];
			es_s1   <= (sml[30:23] == '0) ? 8'd1 : sml[30:23];
			ml_s1   <= {big[30:23] != '0, big[22:0]};
			ms_s1   <= {sml[30:23] != '0, sml[22:0]};
		end
	end

	always_comb begin
		dexp  = el_s1 - es_s1;
		dcap  = (dexp > 8'd63) ? 6'd63 : dexp[5:0];
		alw   = {1'b0, ms_s1, 23'b0, 48'b0} >> dcap;
		lg    = {1'b0, ml_s1, 23'b0};
		sum   = sub_s1 ? (lg - alw[95:48] - 48'(|alw[47:0])) : (lg + alw[95:48]);
		prod  = ml_s1 * ms_s1;
		ecalc = $signed({5'b0, el_s1}) + $signed({5'b0, es_s1}) - 13'sd127;
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			spec_s2 <= spec_s1;
			sres_s2 <= sres_s1;
			zs_s2   <= zs_s1;
			m_s2    <= mul_s1 ? prod : sum;
			st_s2   <= mul_s1 ? 1'b0 : (|alw[47:0]);
			e_s2    <= mul_s1 ? ecalc : $signed({5'b0, el_s1});
			sg_s2   <= mul_s1 ? sub_s1 : sl_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s2) begin
			spec_s3 <= spec_s2;
			sres_s3 <= sres_s2;
			zs_s3   <= zs_s2;
			m_s3    <= m_s2;
			st_s3   <= st_s2;
			e_s3    <= e_s2;
			sg_s3   <= sg_s2;
			lz_s3   <= lzc48(m_s2);
			zero_s3 <= m_s2 == '0;
		end
	end

	always_comb begin
		lzs  = $signed({7'b0, lz_s3});
		sh   = (e_s3 >= lzs) ? (lzs - 13'sd1) : (e_s3 - 13'sd1);
		rneg = 13'(-sh);
		rc   = (rneg > 13'd63) ? 6'd63 : rneg[5:0];
		rw   = {m_s3, 48'b0} >> rc;
		if (!sh[12]) begin
			mn  = m_s3 << sh[5:0];
			stn = st_s3;
		end else begin
			mn  = rw[95:48];
			stn = st_s3 | (|rw[47:0]);
		end
	end

	always_ff @(posedge clk) begin
		if (v_s3) begin
			spec_s4 <= spec_s3;
			sres_s4 <= sres_s3;
			zs_s4   <= zs_s3;
			zero_s4 <= zero_s3;
			sg_s4   <= sg_s3;
			m_s4    <= mn;
			st_s4   <= stn;
			x_s4    <= e_s3 - sh;
		end
	end

	always_comb begin
		inc = m_s4[22] && ((|m_s4[21:0]) || st_s4 || m_s4[23]);
		mag = {x_s4[7:0] - 8'd1, 23'b0} + {7'b0, m_s4[46:23]} + 31'(inc);
		if (spec_s4) fin = sres_s4;
		else if (zero_s4) fin = {zs_s4, 31'b0};
		else if (x_s4 >= 13'sd255) fin = {sg_s4, 8'hFF, 23'b0};
		else fin = {sg_s4, mag};
	end

	always_ff @(posedge clk) begin
		if (v_s4) begin
			res <= fin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			done <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			done <= v_s4;
		end
	end
endmodule

// ===== rtl/core/fpex_back.sv =====
// Back end: register file, lane stores, float unit and the result register.
module fpex_back #(
	parameter int REG_COUNT  = fpex_pkg::REG_COUNT_DEF,
	parameter int LANE_DEPTH = fpex_pkg::LANE_DEPTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_empty,
	input  fpex_pkg::item_t q_dout,
	output logic            pop,
	fpex_out_if.source      result
);
	import fpex_pkg::*;

	localparam int RAW = $clog2(REG_COUNT);
	localparam int LAW = $clog2(LANE_DEPTH);
	localparam logic [1:0] BK_IDLE = 2'd0;
	localparam logic [1:0] BK_EXEC = 2'd1;
	localparam logic [1:0] BK_FPU  = 2'd2;

	function automatic logic fgt(input logic [31:0] x, input logic [31:0] y);
		logic r;
		if (((x[30:23] == 8'hFF) && (x[22:0] != '0)) ||
			((y[30:23] == 8'hFF) && (y[22:0] != '0))) r = 1'b0;
		else if ((x[30:0] == '0) && (y[30:0] == '0)) r = 1'b0;
		else if (x[31] != y[31]) r = y[31];
		else if (!x[31]) r = x[30:0] > y[30:0];
		else r = x[30:0] < y[30:0];
		return r;
	endfunction

	logic [1:0]  state_q;
	item_t       item_q;
	logic        fdone_q;
	logic        rvalid_q;
	logic [2:0]  rstatus_q;
	logic [31:0] rdata_q;

	logic        out_free, is_fp, complete, fpu_start, fpu_done;
	logic [31:0] fpu_res, rf1_rd, rf2_rd, lane_rd_sel;
	logic [31:0] lane_rd [LANE_COUNT];
	logic        rf_we, lane_we;
	logic [31:0] rf_wdata, lane_wdata;

	assign out_free  = !rvalid_q || result.ready;
	assign is_fp     = (item_q.kind == K_ADD) || (item_q.kind == K_MUL);
	assign pop       = (state_q == BK_IDLE) && !q_empty;
	assign fpu_start = (state_q == BK_EXEC) && is_fp;
	assign complete  = out_free && (((state_q == BK_EXEC) && !is_fp) ||
		((state_q == BK_FPU) && (fpu_done || fdone_q)));

	always_comb begin
		case (item_q.lane)
			2'd0: lane_rd_sel = lane_rd[0];
			2'd1: lane_rd_sel = lane_rd[1];
			2'd2: lane_rd_sel = lane_rd[2];
			default: lane_rd_sel = '0;
		endcase
	end

	always_comb begin
		rf_we      = 1'b0;
		rf_wdata   = item_q.data;
		lane_we    = 1'b0;
		lane_wdata = item_q.data;
		case (item_q.kind)
			K_SETC: rf_we = complete;
			K_LOAD: begin
				rf_we    = complete;
				rf_wdata = lane_rd_sel;
			end
			K_ADD, K_MUL: begin
				rf_we    = complete;
				rf_wdata = fpu_res;
			end
			K_MAX: begin
				rf_we    = complete;
				rf_wdata = fgt(rf1_rd, rf2_rd) ? rf1_rd : rf2_rd;
			end
			K_STORE: begin
				lane_we    = complete;
				lane_wdata = rf2_rd;
			end
			K_HWR: lane_we = complete;
			default: rf_we = 1'b0;
		endcase
	end

	fpex_ram #(.WIDTH(32), .DEPTH(REG_COUNT)) u_rf1 (
		.clk(clk), .we(rf_we), .waddr(RAW'(item_q.dst)), .wdata(rf_wdata),
		.re(pop), .raddr(RAW'(q_dout.src1)), .rdata(rf1_rd)
	);

	fpex_ram #(.WIDTH(32), .DEPTH(REG_COUNT)) u_rf2 (
		.clk(clk), .we(rf_we), .waddr(RAW'(item_q.dst)), .wdata(rf_wdata),
		.re(pop), .raddr(RAW'(q_dout.src2)), .rdata(rf2_rd)
	);

	for (genvar g = 0; g < LANE_COUNT; g++) begin : g_lane
		fpex_ram #(.WIDTH(32), .DEPTH(LANE_DEPTH)) u_lane (
			.clk(clk), .we(lane_we && (item_q.lane == 2'(g))),
			.waddr(LAW'(item_q.offset)), .wdata(lane_wdata),
			.re(pop), .raddr(LAW'(q_dout.offset)), .rdata(lane_rd[g])
		);
	end

	fpex_fpu u_fpu (
		.clk(clk), .arst_n(arst_n), .start(fpu_start), .is_mul(item_q.kind == K_MUL),
		.a(rf1_rd), .b(rf2_rd), .done(fpu_done), .res(fpu_res)
	);

	assign result.valid     = rvalid_q;
	assign result.status    = rstatus_q;
	assign result.read_data = rdata_q;

	always_ff @(posedge clk) begin
		if (pop) begin
			item_q <= q_dout;
		end
		if (complete) begin
			rstatus_q <= item_q.status;
			rdata_q   <= (item_q.kind == K_HRD) ? lane_rd_sel : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= BK_IDLE;
			fdone_q  <= 1'b0;
			rvalid_q <= 1'b0;
		end else begin
			if (complete) begin
				rvalid_q <= 1'b1;
			end else if (result.ready) begin
				rvalid_q <= 1'b0;
			end
			if (complete) begin
				fdone_q <= 1'b0;
			end else if (fpu_done) begin
				fdone_q <= 1'b1;
			end
			case (state_q)
				BK_IDLE: if (pop) state_q <= BK_EXEC;
				BK_EXEC: begin
					if (is_fp) state_q <= BK_FPU;
					else if (complete) state_q <= BK_IDLE;
				end
				BK_FPU: if (complete) state_q <= BK_IDLE;
				default: state_q <= BK_IDLE;
			endcase
		end
	end
endmodule

// ===== rtl/core/float_pe_instruction_executor_core.sv =====
// Top level of the float processing element.
// Each instruction or host beat gives exactly one result beat, in order. The front end takes a
// beat in every cycle while its four-entry queue has room, settles the status and the run state
// at once, and hands the work to the back end. For a beat that needs no float arithmetic the back
// end reads the register file and lanes, then writes and posts the result; add and multiply also
// pass through the five-stage float unit before the write. Results leave through an output
// register, and the back end completes no further beat while a result waits to be taken. The
// lanes and register file need no clearing after reset.
module float_pe_instruction_executor_core #(
	parameter int REG_COUNT     = fpex_pkg::REG_COUNT_DEF,
	parameter int LANE_DEPTH    = fpex_pkg::LANE_DEPTH_DEF,
	parameter int PROGRAM_SLOTS = fpex_pkg::PROGRAM_SLOTS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [fpex_pkg::CFG_W-1:0] cfg_wdata,
	fpex_in_if.sink                    item,
	fpex_out_if.source                 result
);
	import fpex_pkg::*;

	item_t q_din;
	item_t q_dout;
	logic  push, full, pop, empty;

	fpex_front #(
		.REG_COUNT(REG_COUNT), .LANE_DEPTH(LANE_DEPTH), .PROGRAM_SLOTS(PROGRAM_SLOTS)
	) u_front (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.item(item), .push(push), .ent(q_din), .full(full)
	);

	fpex_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .din(q_din), .full(full),
		.pop(pop), .dout(q_dout), .empty(empty)
	);

	fpex_back #(.REG_COUNT(REG_COUNT), .LANE_DEPTH(LANE_DEPTH)) u_back (
		.clk(clk), .arst_n(arst_n), .q_empty(empty), .q_dout(q_dout), .pop(pop),
		.result(result)
	);
endmodule
